@@ design/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// LFU cache package
// Sizes, widths and sequencer state codes for the LFU key/value cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W   = $clog2(ENTRIES + 1);
  localparam int unsigned AGE_W   = IDX_W;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } lfu_state_e;

endpackage

@@ design/lfu_cache_lookup_and_replace.sv @@
// ----------------------------------------------------------------------------
// LFU cache lookup and replace
// Fully associative key/value store, least-frequently-used replacement with
// least-recently-used tie break.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries one word per request:
//   action_i (0 = get, 1 = put), key_i and value_i. The output channel
//   (out_valid_o/out_ready_i) returns one word per request: found_o,
//   read_value_o (stored value on a get hit, else 0) and evicted_o.
//   cache_capacity_we_i writes cache_capacity_i (0 acts as 1, above the
//   entry count acts as the entry count); write it only while idle.
// Sequence:
//   A request is accepted in the idle state, then scanned at one entry
//   per cycle through the shared key/count compare unit, which finds the
//   hit, the first free slot and the victim, then written back; in_ready_o
//   is high only in idle, so the next request waits for the last write-back.
// Reset:
//   All entries become invalid, occupancy clears, capacity returns to 16.
// Stall:
//   A result waits in the output register; the next request may be taken
//   meanwhile, but its write-back holds until the output register is free.
// ----------------------------------------------------------------------------
module lfu_cache_lookup_and_replace (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [lfu_pkg::KEY_W-1:0]   key_i,
  input  logic [lfu_pkg::DATA_W-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [lfu_pkg::DATA_W-1:0]  read_value_o,
  output logic                        evicted_o,
  input  logic                        cache_capacity_we_i,
  input  logic [lfu_pkg::CAP_W-1:0]   cache_capacity_i
);
  import lfu_pkg::*;

  // Sequencer
  lfu_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q;
  logic             idx_last;

  // Configuration and occupancy
  logic [CAP_W-1:0] cap_cfg_q;
  logic [OCC_W-1:0] cap_q;
  logic [OCC_W-1:0] occ_q;

  // Request held for the whole scan
  logic              act_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] val_q;

  // Entry storage: valid bits reset, payload does not
  logic [ENTRIES-1:0] valid_q;
  logic [KEY_W-1:0]   key_mem_q  [ENTRIES];
  logic [DATA_W-1:0]  data_mem_q [ENTRIES];
  logic [CNT_W-1:0]   cnt_mem_q  [ENTRIES];
  logic [AGE_W-1:0]   age_q      [ENTRIES];

  // Scan results
  logic              hit_q, free_q, vic_q;
  logic [IDX_W-1:0]  hit_idx_q, free_idx_q, vic_idx_q;
  logic [DATA_W-1:0] hit_data_q;
  logic [CNT_W-1:0]  hit_cnt_q, vic_cnt_q;
  logic [AGE_W-1:0]  hit_age_q, vic_age_q;

  // Output register
  logic              out_valid_q, found_q, evicted_q;
  logic [DATA_W-1:0] rdata_q;

  // Shared compare unit: one entry per scan cycle
  logic             cur_valid;
  logic [CNT_W-1:0] cur_cnt;
  logic [AGE_W-1:0] cur_age;
  logic             key_eq;
  logic             vic_better;

  assign cur_valid = valid_q[idx_q];
  assign cur_cnt   = cnt_mem_q[idx_q];
  assign cur_age   = age_q[idx_q];
  assign key_eq    = (key_mem_q[idx_q] == key_q);
  assign vic_better = !vic_q || (cur_cnt < vic_cnt_q) ||
                      ((cur_cnt == vic_cnt_q) && (cur_age > vic_age_q));
  assign idx_last  = (idx_q == IDX_W'(ENTRIES - 1));

  // Write-back decisions
  logic             do_upd;
  logic             upd_any, upd_fill, upd_evict, age_all;
  logic [IDX_W-1:0] slot;
  logic [AGE_W-1:0] age_lim;
  logic [CNT_W-1:0] hit_cnt_inc;

  assign do_upd = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    upd_any   = hit_q || (act_q == ACT_PUT);
    upd_fill  = !hit_q && (act_q == ACT_PUT) &&
                (((occ_q < cap_q) && free_q) || !vic_q);
    upd_evict = !hit_q && (act_q == ACT_PUT) && !upd_fill;
    age_all   = upd_fill;
    if (hit_q) begin
      slot    = hit_idx_q;
      age_lim = hit_age_q;
    end else if (upd_fill) begin
      slot    = free_q ? free_idx_q : '0;
      age_lim = vic_age_q;
    end else begin
      slot    = vic_idx_q;
      age_lim = vic_age_q;
    end
    hit_cnt_inc = (hit_cnt_q == CNT_MAX) ? hit_cnt_q : hit_cnt_q + CNT_W'(1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (idx_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (do_upd) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cap_cfg_q   <= CAP_RESET;
      occ_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      vic_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cache_capacity_we_i) cap_cfg_q <= cache_capacity_i;

      if (state_q == S_IDLE) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        vic_q  <= 1'b0;
      end else if (state_q == S_SCAN) begin
        idx_q <= idx_q + IDX_W'(1);
        if (cur_valid && key_eq && !hit_q) hit_q <= 1'b1;
        if (!cur_valid && !free_q) free_q <= 1'b1;
        if (cur_valid) vic_q <= 1'b1;
      end

      // Drop the result once taken, load the new one at write-back
      if (do_upd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (do_upd && upd_fill) begin
        valid_q[slot] <= 1'b1;
        occ_q         <= occ_q + OCC_W'(1);
      end
    end
  end

  // Request capture, scan bookkeeping and entry payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= action_i;
      key_q <= key_i;
      val_q <= value_i;
      // Clamp capacity to 1 .. ENTRIES
      if (cap_cfg_q == '0) begin
        cap_q <= OCC_W'(1);
      end else if (32'(cap_cfg_q) > ENTRIES) begin
        cap_q <= OCC_W'(ENTRIES);
      end else begin
        cap_q <= OCC_W'(cap_cfg_q);
      end
    end

    if (state_q == S_SCAN) begin
      if (cur_valid && key_eq && !hit_q) begin
        hit_idx_q  <= idx_q;
        hit_data_q <= data_mem_q[idx_q];
        hit_cnt_q  <= cur_cnt;
        hit_age_q  <= cur_age;
      end
      if (!cur_valid && !free_q) free_idx_q <= idx_q;
      if (cur_valid && vic_better) begin
        vic_idx_q <= idx_q;
        vic_cnt_q <= cur_cnt;
        vic_age_q <= cur_age;
      end
    end

    if (do_upd) begin
      found_q   <= hit_q;
      rdata_q   <= (hit_q && (act_q == ACT_GET)) ? hit_data_q : '0;
      evicted_q <= upd_evict;

      if (upd_any) begin
        // Age valid others below the limit (all on a fill), make slot newest
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && (IDX_W'(i) != slot) && (age_all || (age_q[i] < age_lim))) begin
            age_q[i] <= age_q[i] + AGE_W'(1);
          end
        end
        age_q[slot] <= '0;

        if (hit_q) begin
          cnt_mem_q[slot] <= hit_cnt_inc;
          if (act_q == ACT_PUT) data_mem_q[slot] <= val_q;
        end else begin
          key_mem_q[slot]  <= key_q;
          data_mem_q[slot] <= val_q;
          cnt_mem_q[slot]  <= CNT_W'(1);
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = rdata_q;
  assign evicted_o    = evicted_q;

endmodule

@@ tb/lfu_cache_lookup_and_replace_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache lookup and replace testbench
// Drives get and put words through the request channel, predicts every
// result with a cycle-free model of the cache (frequency replacement, age
// tie break, capacity clamping) and checks each returned word in order.
// Directed tests cover eviction order, field extremes and capacity changes;
// random phases at several capacities follow, with stalls on both sides.
// ----------------------------------------------------------------------------
module lfu_cache_lookup_and_replace_tb;
  import lfu_pkg::*;

  // Expected content of one returned word.
  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
  } lookup_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              action_i;
  logic [KEY_W-1:0]  key_i;
  logic [DATA_W-1:0] value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              found_o;
  logic [DATA_W-1:0] read_value_o;
  logic              evicted_o;
  logic              cache_capacity_we_i;
  logic [CAP_W-1:0]  cache_capacity_i;

  lfu_cache_lookup_and_replace dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .key_i              (key_i),
    .value_i            (value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .found_o            (found_o),
    .read_value_o       (read_value_o),
    .evicted_o          (evicted_o),
    .cache_capacity_we_i(cache_capacity_we_i),
    .cache_capacity_i   (cache_capacity_i)
  );

  // Cache model: one copy of every entry plus occupancy and capacity.
  logic              slot_used [ENTRIES];
  logic [KEY_W-1:0]  slot_key  [ENTRIES];
  logic [DATA_W-1:0] slot_data [ENTRIES];
  logic [CNT_W-1:0]  slot_uses [ENTRIES];
  int unsigned       slot_age  [ENTRIES];   // 0 = most recently used
  int unsigned       fill_level;
  logic [CAP_W-1:0]  capacity_reg;

  // Results predicted at request acceptance, oldest first.
  lookup_result_t pending_results[$];
  lookup_result_t head_result;

  int unsigned words_sent;
  int unsigned hits_seen;
  int unsigned evictions_seen;
  int unsigned error_count;
  bit          no_idle;   // set to run a stretch with no gaps on either side

  // Key pool for the random phases; reuse drives hits and frequency spread.
  logic [KEY_W-1:0] key_pool [40];

  // --------------------------------------------------------------------------
  // Clock, 4 ns period.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the cache.
  // --------------------------------------------------------------------------
  function automatic void clear_model();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_data[i] = '0;
      slot_uses[i] = '0;
      slot_age[i]  = 0;
    end
    fill_level   = 0;
    capacity_reg = CAP_RESET;
  endfunction

  // Make slot s newest; every other live entry younger than limit ages by one.
  function automatic void promote_slot(input int s, input int unsigned limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && i != s && slot_age[i] < limit) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // Apply one request to the model and return the word the block must send.
  function automatic lookup_result_t lookup_and_update(input logic act,
                                                       input logic [KEY_W-1:0] k,
                                                       input logic [DATA_W-1:0] v);
    lookup_result_t r;
    int unsigned    cap_eff;
    int             hit_at;
    int             slot;
    r       = '0;
    cap_eff = (capacity_reg == '0) ? 1 : int'(capacity_reg);
    if (cap_eff > ENTRIES) cap_eff = ENTRIES;
    hit_at = -1;
    slot   = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_at < 0 && slot_used[i] && slot_key[i] == k) hit_at = i;
    end
    if (hit_at >= 0) begin
      r.found = 1'b1;
      if (act == ACT_GET) r.read_value = slot_data[hit_at];
      else slot_data[hit_at] = v;
      if (slot_uses[hit_at] != CNT_MAX) slot_uses[hit_at]++;
      promote_slot(hit_at, slot_age[hit_at]);
    end else if (act == ACT_PUT) begin
      // Take the lowest free slot while under capacity.
      if (fill_level < cap_eff) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !slot_used[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        slot_used[slot] = 1'b1;
        fill_level++;
        promote_slot(slot, ENTRIES);
      end else begin
        // Victim: lowest use count, oldest among equal counts.
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && (slot < 0 || slot_uses[i] < slot_uses[slot] ||
              (slot_uses[i] == slot_uses[slot] && slot_age[i] > slot_age[slot])))
            slot = i;
        end
        if (slot < 0) begin
          slot = 0;
          slot_used[0] = 1'b1;
          fill_level++;
          promote_slot(0, ENTRIES);
        end else begin
          r.evicted = 1'b1;
          promote_slot(slot, slot_age[slot]);
        end
      end
      slot_key[slot]  = k;
      slot_data[slot] = v;
      slot_uses[slot] = 1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------
  // Enter at a falling edge with valid low. Raise valid at a later falling
  // edge, hold the word until accepted, predict, then drop valid.
  task automatic send_word(input logic act, input logic [KEY_W-1:0] k,
                           input logic [DATA_W-1:0] v);
    do @(negedge clk_i); while (!no_idle && $urandom_range(0, 99) < 10);
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= k;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(lookup_and_update(act, k, v));
    words_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Hold off until every predicted word has come back.
  task automatic wait_for_results();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Write the capacity register with the block idle.
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait_for_results();
    repeat (4) @(negedge clk_i);
    cache_capacity_i    <= c;
    cache_capacity_we_i <= 1'b1;
    @(negedge clk_i);
    cache_capacity_we_i <= 1'b0;
    capacity_reg = c;
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall now and then, with an occasional long hold.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 2) begin
        hold = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare every accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request outstanding");
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (found_o !== head_result.found) begin
          $error("found: expected %0b, actual %0b", head_result.found, found_o);
          error_count++;
        end
        if (read_value_o !== head_result.read_value) begin
          $error("read_value: expected %08h, actual %08h", head_result.read_value,
                 read_value_o);
          error_count++;
        end
        if (evicted_o !== head_result.evicted) begin
          $error("evicted: expected %0b, actual %0b", head_result.evicted, evicted_o);
          error_count++;
        end
        if (found_o === 1'b1) hits_seen++;
        if (evicted_o === 1'b1) evictions_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------
  // Capacity 3 from empty: lowest count goes first, oldest among equal counts.
  task automatic test_frequency_eviction();
    logic [KEY_W-1:0] ka, kb, kc, kd, ke;
    ka = 32'h1000_0001; kb = 32'h1000_0002; kc = 32'h1000_0003;
    kd = 32'h1000_0004; ke = 32'h1000_0005;
    set_capacity(CAP_W'(3));
    send_word(ACT_PUT, ka, 32'hA5A5_0001);
    send_word(ACT_PUT, kb, 32'hA5A5_0002);
    send_word(ACT_PUT, kc, 32'hA5A5_0003);
    send_word(ACT_GET, ka, '0);
    send_word(ACT_GET, ka, '0);
    send_word(ACT_GET, kb, '0);
    send_word(ACT_PUT, kd, 32'hA5A5_0004);   // drop kc, count 1
    send_word(ACT_GET, kc, '0);              // miss
    send_word(ACT_GET, kd, '0);              // kb and kd now tie at 2
    send_word(ACT_PUT, ke, 32'hA5A5_0005);   // drop kb, the older of the tie
    send_word(ACT_GET, kb, '0);
  endtask

  // All-zero and all-one keys and values; put hit overwrites data.
  task automatic test_field_extremes();
    set_capacity('1);                        // above entry count, clamps
    send_word(ACT_GET, '0, '1);
    send_word(ACT_PUT, '0, '0);
    send_word(ACT_PUT, '1, '1);
    send_word(ACT_GET, '1, '0);
    send_word(ACT_PUT, '0, '1);
    send_word(ACT_GET, '0, '0);
  endtask

  // Lower capacity below occupancy: nothing drops at the write, later puts
  // swap one entry for one.
  task automatic test_capacity_shrink();
    set_capacity(CAP_W'(2));
    send_word(ACT_PUT, 32'h2000_0001, 32'h1234_5678);
    send_word(ACT_PUT, 32'h2000_0002, 32'h8765_4321);
    send_word(ACT_GET, 32'h2000_0001, '0);
  endtask

  // Capacity zero acts as one.
  task automatic test_capacity_extremes();
    set_capacity('0);
    send_word(ACT_PUT, 32'h3000_0001, 32'hDEAD_BEEF);
    send_word(ACT_GET, 32'h3000_0001, '0);
    set_capacity(CAP_W'(1));
    send_word(ACT_PUT, 32'h3000_0002, 32'hCAFE_F00D);
  endtask

  // Random phases: mostly keys reused from a small skewed pool, some fresh.
  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [6];
    int unsigned      pool_n;
    int unsigned      cap_eff;
    int unsigned      idx;
    logic [KEY_W-1:0] k;
    caps[0] = CAP_W'(16);
    caps[1] = CAP_W'(1);
    caps[2] = '1;
    caps[3] = '0;
    caps[4] = CAP_W'(5);
    caps[5] = CAP_W'($urandom_range(0, 31));
    for (int p = 0; p < 6; p++) begin
      set_capacity(caps[p]);
      cap_eff = (caps[p] == '0) ? 1 : ((caps[p] > ENTRIES) ? ENTRIES : caps[p]);
      pool_n  = 2 * cap_eff + 3;
      if (pool_n > 40) pool_n = 40;
      for (int i = 0; i < 40; i++) key_pool[i] = $urandom;
      key_pool[pool_n - 1] = '1;
      key_pool[pool_n - 2] = '0;
      no_idle = (p == 2);                    // one long stretch with no gaps
      for (int n = 0; n < 140; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          idx = $urandom_range(0, $urandom_range(0, pool_n - 1));
          k   = key_pool[idx];
        end else begin
          k = $urandom;
        end
        send_word(logic'($urandom_range(0, 1)), k, $urandom);
        // Let the result side catch up completely now and then.
        if (n % 50 == 49) wait_for_results();
      end
      no_idle = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    in_valid_i          = 1'b0;
    action_i            = ACT_GET;
    key_i               = '0;
    value_i             = '0;
    cache_capacity_we_i = 1'b0;
    cache_capacity_i    = CAP_RESET;
    rst_ni              = 1'b0;
    no_idle             = 1'b0;
    words_sent          = 0;
    hits_seen           = 0;
    evictions_seen      = 0;
    error_count         = 0;
    clear_model();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_frequency_eviction();
    test_field_extremes();
    test_capacity_shrink();
    test_capacity_extremes();
    test_random_traffic();

    // Drain, then give a stray word time to show up.
    wait_for_results();
    repeat (3 * (ENTRIES + 2)) @(posedge clk_i);

    $display("%0d requests checked: %0d hits, %0d evictions returned",
             words_sent, hits_seen, evictions_seen);
    $display("capacity settings 0, 1, 2, 3, 5, 16, 31 and a random one, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ lfu_cache_lookup_and_replace.f @@
design/lfu_pkg.sv
design/lfu_cache_lookup_and_replace.sv
tb/lfu_cache_lookup_and_replace_tb.sv
